// ===== rtl/ppc_pkg.sv =====
package ppc_pkg;

	// Configuration register indexes.
	localparam logic [3:0] CFG_NORMAL_X     = 4'd0;
	localparam logic [3:0] CFG_NORMAL_Y     = 4'd1;
	localparam logic [3:0] CFG_NORMAL_Z     = 4'd2;
	localparam logic [3:0] CFG_PLANE_OFFSET = 4'd3;
	localparam logic [3:0] CFG_SMOOTHNESS   = 4'd4;
	localparam logic [3:0] CFG_BOUNCE       = 4'd5;
	localparam logic [3:0] CFG_MODE_BITS    = 4'd6;
	localparam logic [3:0] CFG_PAINT_COLOR  = 4'd7;

	// Bit positions inside mode_bits.
	localparam int MODE_INVERT     = 0;
	localparam int MODE_KILL       = 1;
	localparam int MODE_NO_RESOLVE = 2;
	localparam int MODE_RECOLOR    = 3;

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic signed [17:0] normal_x;
		logic signed [17:0] normal_y;
		logic signed [17:0] normal_z;
		logic signed [31:0] plane_offset;
		logic [17:0]        smoothness;
		logic [17:0]        bounce;
		logic [3:0]         mode_bits;
		logic [31:0]        paint_color;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] prev_x;
		logic signed [31:0] prev_y;
		logic signed [31:0] prev_z;
		logic               collided_before;
		logic [31:0]        frame_now;
		logic [31:0]        frame_base_in;
		logic               pass_start;
	} in_t;

	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_pos_z;
		logic signed [31:0] new_prev_x;
		logic signed [31:0] new_prev_y;
		logic signed [31:0] new_prev_z;
		logic               hit;
		logic               killed;
		logic               recolor;
		logic [31:0]        frame_base_out;
		logic [31:0]        hit_total;
		logic [31:0]        ticks_since_hit;
	} out_t;

	// Classified particle handed from the front to the back.
	typedef struct packed {
		logic signed [31:0] p0;
		logic signed [31:0] p1;
		logic signed [31:0] p2;
		logic signed [31:0] q0;
		logic signed [31:0] q1;
		logic signed [31:0] q2;
		logic signed [53:0] dexact;
		logic               hit;
		logic               killed;
		logic               resolve;
		logic               recolor;
		logic [31:0]        frame_base;
		logic [31:0]        hit_total;
		logic [31:0]        ticks;
	} task_t;

endpackage

// ===== rtl/ppc_front.sv =====
module ppc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  ppc_pkg::cfg_t  cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  ppc_pkg::in_t   in_data,
	output logic           push_valid,
	input  logic           push_ready,
	output ppc_pkg::task_t push_data
);
	import ppc_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_MUL  = 3'b010,
		F_SUM  = 3'b100
	} fstate_t;

	fstate_t            state_q;
	in_t                item_q;
	logic signed [49:0] prod_s1 [3];
	logic [31:0]        count_q;
	logic [31:0]        idle_q;
	logic signed [53:0] off_al;
	logic signed [53:0] dexact;
	logic               hit;
	logic [31:0]        count_nx;
	logic [31:0]        idle_nx;

	assign in_ready   = (state_q == F_IDLE);
	assign push_valid = (state_q == F_SUM);

	// Signed distance in Q32.32 and the hit test on its sign.
	assign off_al = {{6{cfg.plane_offset[31]}}, cfg.plane_offset, 16'h0000};
	assign dexact = prod_s1[0] + prod_s1[1] + prod_s1[2] - off_al;
	assign hit    = cfg.mode_bits[MODE_INVERT] ? ~dexact[53] : dexact[53];

	// Counter updates: the pass tick comes first, a hit then clears it.
	always_comb begin
		idle_nx = idle_q;
		if (item_q.pass_start && idle_q != COUNT_MAX)
			idle_nx = idle_q + 32'd1;
		count_nx = count_q;
		if (hit) begin
			idle_nx = '0;
			if (count_q != COUNT_MAX)
				count_nx = count_q + 32'd1;
		end
	end

	// Transaction handed to the back.
	always_comb begin
		push_data.p0         = item_q.pos_x;
		push_data.p1         = item_q.pos_y;
		push_data.p2         = item_q.pos_z;
		push_data.q0         = item_q.prev_x;
		push_data.q1         = item_q.prev_y;
		push_data.q2         = item_q.prev_z;
		push_data.dexact     = dexact;
		push_data.hit        = hit;
		push_data.killed     = hit & cfg.mode_bits[MODE_KILL];
		push_data.resolve    = hit & ~cfg.mode_bits[MODE_KILL]
		                       & ~cfg.mode_bits[MODE_NO_RESOLVE];
		push_data.recolor    = hit & ~cfg.mode_bits[MODE_KILL] & cfg.mode_bits[MODE_RECOLOR];
		push_data.frame_base = (hit && !item_q.collided_before) ?
		                       item_q.frame_now : item_q.frame_base_in;
		push_data.hit_total  = count_nx;
		push_data.ticks      = idle_nx;
	end

	// Item capture and the dot product lanes.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_q <= in_data;
		if (state_q == F_MUL) begin
			prod_s1[0] <= cfg.normal_x * item_q.pos_x;
			prod_s1[1] <= cfg.normal_y * item_q.pos_y;
			prod_s1[2] <= cfg.normal_z * item_q.pos_z;
		end
	end

	// Sequencer and persistent counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			count_q <= '0;
			idle_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid)
						state_q <= F_MUL;
				end
				F_MUL: begin
					state_q <= F_SUM;
				end
				F_SUM: begin
					if (push_ready) begin
						state_q <= F_IDLE;
						count_q <= count_nx;
						idle_q  <= idle_nx;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/ppc_queue.sv =====
module ppc_queue #(
	parameter int Depth = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  ppc_pkg::task_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output ppc_pkg::task_t pop_data
);
	import ppc_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	task_t             entry_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/ppc_back.sv =====
module ppc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ppc_pkg::cfg_t  cfg,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  ppc_pkg::task_t pop_data,
	output logic           out_valid,
	input  logic           out_ready,
	output ppc_pkg::out_t  out_data
);
	import ppc_pkg::*;

	typedef enum logic [6:0] {
		B_IDLE = 7'b0000001,
		B_T    = 7'b0000010,
		B_VD   = 7'b0000100,
		B_VP   = 7'b0001000,
		B_SC   = 7'b0010000,
		B_FIN  = 7'b0100000,
		B_OUT  = 7'b1000000
	} bstate_t;

	bstate_t            state_q;
	task_t              task_q;
	out_t               out_q;
	logic signed [56:0] mt_q [3];
	logic signed [50:0] mv_q [3];
	logic signed [55:0] mp_q [3];
	logic signed [60:0] ms_q [3];
	logic signed [59:0] mb_q [3];
	logic signed [42:0] pp_q [3];
	logic signed [37:0] vd_q;

	logic signed [17:0] nv [3];
	logic signed [31:0] pv [3];
	logic signed [31:0] qv [3];
	logic signed [32:0] vv [3];
	logic signed [54:0] dq_r;
	logic signed [38:0] dq;
	logic signed [57:0] t_r [3];
	logic signed [52:0] vsum;
	logic signed [53:0] vd_r;
	logic signed [56:0] vp_r [3];
	logic signed [40:0] vperp [3];
	logic signed [41:0] vpar [3];
	logic signed [61:0] a_r [3];
	logic signed [60:0] b_r [3];
	logic signed [47:0] pn [3];
	logic signed [47:0] qn [3];
	logic signed [31:0] pout [3];
	logic signed [31:0] qout [3];

	// Clamp to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
		logic signed [31:0] r;
		if (x > 48'sh0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (x < -48'sh0000_8000_0000)
			r = 32'sh8000_0000;
		else
			r = x[31:0];
		return r;
	endfunction

	assign pop_ready = (state_q == B_IDLE);
	assign out_valid = (state_q == B_OUT);
	assign out_data  = out_q;

	assign nv[0] = cfg.normal_x;
	assign nv[1] = cfg.normal_y;
	assign nv[2] = cfg.normal_z;
	assign pv[0] = task_q.p0;
	assign pv[1] = task_q.p1;
	assign pv[2] = task_q.p2;
	assign qv[0] = task_q.q0;
	assign qv[1] = task_q.q1;
	assign qv[2] = task_q.q2;

	// Distance rounded to Q16.16 and the normal component of the motion.
	assign dq_r = {task_q.dexact[53], task_q.dexact} + 55'sd32768;
	assign dq   = dq_r[54:16];
	assign vsum = mv_q[0] + mv_q[1] + mv_q[2];
	assign vd_r = {vsum[52], vsum} + 54'sd32768;

	// Per-lane rounding and the final recombination.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vv[i]    = {pv[i][31], pv[i]} - {qv[i][31], qv[i]};
			t_r[i]   = {mt_q[i][56], mt_q[i]} + 58'sd32768;
			vp_r[i]  = mp_q[i] + 57'sd32768;
			vperp[i] = vp_r[i][56:16];
			vpar[i]  = vv[i] - vperp[i];
			a_r[i]   = {ms_q[i][60], ms_q[i]} + 62'sd32768;
			b_r[i]   = {mb_q[i][59], mb_q[i]} + 61'sd32768;
			if (task_q.resolve) begin
				pn[i] = pp_q[i];
				qn[i] = pp_q[i] - $signed(a_r[i][61:16]) + $signed(b_r[i][60:16]);
			end else begin
				pn[i] = pv[i];
				qn[i] = qv[i];
			end
			pout[i] = sat32(pn[i]);
			qout[i] = sat32(qn[i]);
		end
	end

	// Datapath registers of the three multiplier lanes.
	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready)
			task_q <= pop_data;
		for (int i = 0; i < 3; i++) begin
			if (state_q == B_T) begin
				mt_q[i] <= nv[i] * dq;
				mv_q[i] <= nv[i] * vv[i];
			end
			if (state_q == B_VD)
				pp_q[i] <= pv[i] - $signed(t_r[i][57:16]);
			if (state_q == B_VP)
				mp_q[i] <= nv[i] * vd_q;
			if (state_q == B_SC) begin
				ms_q[i] <= vpar[i] * $signed({1'b0, cfg.smoothness});
				mb_q[i] <= vperp[i] * $signed({1'b0, cfg.bounce});
			end
		end
		if (state_q == B_VD)
			vd_q <= vd_r[53:16];
		if (state_q == B_FIN) begin
			out_q.new_pos_x       <= pout[0];
			out_q.new_pos_y       <= pout[1];
			out_q.new_pos_z       <= pout[2];
			out_q.new_prev_x      <= qout[0];
			out_q.new_prev_y      <= qout[1];
			out_q.new_prev_z      <= qout[2];
			out_q.hit             <= task_q.hit;
			out_q.killed          <= task_q.killed;
			out_q.recolor         <= task_q.recolor;
			out_q.frame_base_out  <= task_q.frame_base;
			out_q.hit_total       <= task_q.hit_total;
			out_q.ticks_since_hit <= task_q.ticks;
		end
	end

	// Step sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid)
						state_q <= pop_data.resolve ? B_T : B_FIN;
				end
				B_T:  state_q <= B_VD;
				B_VD: state_q <= B_VP;
				B_VP: state_q <= B_SC;
				B_SC: state_q <= B_FIN;
				B_FIN: state_q <= B_OUT;
				B_OUT: begin
					if (out_ready)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/plane_particle_collision.sv =====
// Plane collider for Verlet particles in Q16.16. A front sequencer captures
// a particle, forms the plane distance on three multiplier lanes and decides
// the hit, the counters and the flags; a queue of QueueDepth transactions then
// feeds a back sequencer. The back takes a particle that it passes through
// from idle to its finish and output states; one that it resolves first goes
// through its T, VD, VP and SC steps over the three lanes, which push it out of
// the plane, rebuild its previous position and set the throughput for resolved
// hits. The front, busy until it hands each item on, sets it otherwise.
// Configuration must be written only while idle; the block does not enforce it.
module plane_particle_collision #(
	parameter int QueueDepth = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [3:0]    cfg_idx,
	input  logic [31:0]   cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  ppc_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output ppc_pkg::out_t out_data
);
	import ppc_pkg::*;

	cfg_t  cfg_q;
	logic  push_valid;
	logic  push_ready;
	task_t push_data;
	logic  pop_valid;
	logic  pop_ready;
	task_t pop_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_x     <= '0;
			cfg_q.normal_y     <= '0;
			cfg_q.normal_z     <= 18'sd65536;
			cfg_q.plane_offset <= '0;
			cfg_q.smoothness   <= 18'd65536;
			cfg_q.bounce       <= '0;
			cfg_q.mode_bits    <= '0;
			cfg_q.paint_color  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_NORMAL_X:     cfg_q.normal_x     <= cfg_wdata[17:0];
				CFG_NORMAL_Y:     cfg_q.normal_y     <= cfg_wdata[17:0];
				CFG_NORMAL_Z:     cfg_q.normal_z     <= cfg_wdata[17:0];
				CFG_PLANE_OFFSET: cfg_q.plane_offset <= cfg_wdata;
				CFG_SMOOTHNESS:   cfg_q.smoothness   <= cfg_wdata[17:0];
				CFG_BOUNCE:       cfg_q.bounce       <= cfg_wdata[17:0];
				CFG_MODE_BITS:    cfg_q.mode_bits    <= cfg_wdata[3:0];
				CFG_PAINT_COLOR:  cfg_q.paint_color  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ppc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	ppc_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	ppc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// A killed or recolored particle must be a hit, and never both.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.hit || (!out_data.killed && !out_data.recolor))
		               && !(out_data.killed && out_data.recolor)))
		else $error("inconsistent hit flags");

	// A hit always clears the tick counter.
	a_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.hit) |-> (out_data.ticks_since_hit == '0))
		else $error("ticks not cleared on hit");

	// The front works on one particle at a time.
	a_front: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("front accepted while busy");

endmodule

// ===== tb/plane_particle_collision_tb.sv =====
`timescale 1ns / 1ps

module plane_particle_collision_tb;
	import ppc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int RANDOM_ITEMS   = 1650;
	localparam int LONG_HOLD      = 300;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [3:0]  cfg_idx;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;

	// Predictor copy of the configuration and the counters.
	cfg_t        pred_cfg;
	logic [31:0] pred_hits;
	logic [31:0] pred_ticks;

	out_t        pending_results[$];
	int          error_count;
	int          idle_cycles;
	bit          hold_receiver;
	bit          stim_done;

	plane_particle_collision i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Floor of a Q32.32 value rounded half up to Q16.16.
	function automatic logic signed [127:0] round_q16(input logic signed [127:0] x);
		return (x + 128'sd32768) >>> 16;
	endfunction

	function automatic logic [31:0] clamp32(input logic signed [127:0] x);
		if (x > 128'sd2147483647) return 32'h7FFF_FFFF;
		if (x < -128'sd2147483648) return 32'h8000_0000;
		return x[31:0];
	endfunction

	// Computes the collision response of one particle and updates the counters.
	function automatic out_t collide_particle(input in_t pin);
		out_t r;
		logic signed [127:0] nrm[3];
		logic signed [127:0] p[3];
		logic signed [127:0] q[3];
		logic signed [127:0] v[3];
		logic signed [127:0] dexact, dq, vd, t, vperp, vpar;
		logic hit;
		nrm[0] = 128'(pred_cfg.normal_x);
		nrm[1] = 128'(pred_cfg.normal_y);
		nrm[2] = 128'(pred_cfg.normal_z);
		p[0] = 128'(pin.pos_x);  p[1] = 128'(pin.pos_y);  p[2] = 128'(pin.pos_z);
		q[0] = 128'(pin.prev_x); q[1] = 128'(pin.prev_y); q[2] = 128'(pin.prev_z);
		r = '0;
		r.frame_base_out = pin.frame_base_in;
		if (pin.pass_start && pred_ticks != COUNT_MAX) pred_ticks++;
		dexact = nrm[0] * p[0] + nrm[1] * p[1] + nrm[2] * p[2]
			- 128'(pred_cfg.plane_offset) * 128'sd65536;
		hit = pred_cfg.mode_bits[MODE_INVERT] ? (dexact >= 0) : (dexact < 0);
		if (hit) begin
			pred_ticks = '0;
			if (pred_hits != COUNT_MAX) pred_hits++;
			if (!pin.collided_before) r.frame_base_out = pin.frame_now;
			if (pred_cfg.mode_bits[MODE_KILL]) begin
				r.killed = 1'b1;
			end else begin
				if (!pred_cfg.mode_bits[MODE_NO_RESOLVE]) begin
					dq = round_q16(dexact);
					for (int i = 0; i < 3; i++) begin
						t = round_q16(nrm[i] * dq);
						p[i] = p[i] - t;
						q[i] = q[i] - t;
						v[i] = p[i] - q[i];
					end
					vd = round_q16(nrm[0] * v[0] + nrm[1] * v[1] + nrm[2] * v[2]);
					for (int i = 0; i < 3; i++) begin
						vperp = round_q16(nrm[i] * vd);
						vpar = v[i] - vperp;
						q[i] = p[i] - round_q16(vpar * 128'(pred_cfg.smoothness))
							+ round_q16(vperp * 128'(pred_cfg.bounce));
					end
				end
				r.recolor = pred_cfg.mode_bits[MODE_RECOLOR];
			end
		end
		r.new_pos_x  = clamp32(p[0]);
		r.new_pos_y  = clamp32(p[1]);
		r.new_pos_z  = clamp32(p[2]);
		r.new_prev_x = clamp32(q[0]);
		r.new_prev_y = clamp32(q[1]);
		r.new_prev_z = clamp32(q[2]);
		r.hit        = hit;
		r.hit_total  = pred_hits;
		r.ticks_since_hit = pred_ticks;
		return r;
	endfunction

	task automatic write_reg(input logic [3:0] idx, input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_NORMAL_X:     pred_cfg.normal_x     = value[17:0];
			CFG_NORMAL_Y:     pred_cfg.normal_y     = value[17:0];
			CFG_NORMAL_Z:     pred_cfg.normal_z     = value[17:0];
			CFG_PLANE_OFFSET: pred_cfg.plane_offset = value;
			CFG_SMOOTHNESS:   pred_cfg.smoothness   = value[17:0];
			CFG_BOUNCE:       pred_cfg.bounce       = value[17:0];
			CFG_MODE_BITS:    pred_cfg.mode_bits    = value[3:0];
			CFG_PAINT_COLOR:  pred_cfg.paint_color  = value;
			default: ;
		endcase
	endtask

	// Drops valid and waits until every expected result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Offers one particle and, once it is taken, queues its expected result.
	// Valid stays high after the transaction unless a gap follows.
	task automatic send_particle(input in_t pin, input bit gaps);
		out_t r;
		int   gap;
		gap = 0;
		if (gaps) begin
			if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 40);
			else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= pin;
		do @(posedge clk); while (!in_ready);
		r = collide_particle(pin);
		pending_results.push_back(r);
	endtask

	function automatic logic [31:0] rand_coord(input int span_sel);
		case (span_sel)
			0: return $urandom();
			1: return 32'(int'($urandom_range(0, 2 << 20)) - (1 << 20));
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
		endcase
	endfunction

	function automatic in_t rand_particle();
		in_t pin;
		int sel;
		sel = $urandom_range(0, 9) < 7 ? 1 : $urandom_range(0, 3);
		pin.pos_x = rand_coord(sel);
		pin.pos_y = rand_coord(sel);
		pin.pos_z = rand_coord(sel);
		// Previous position mostly near the current one, like a real step.
		pin.prev_x = (sel == 1) ? pin.pos_x + 32'(int'($urandom_range(0, 8192)) - 4096)
			: rand_coord(sel);
		pin.prev_y = (sel == 1) ? pin.pos_y + 32'(int'($urandom_range(0, 8192)) - 4096)
			: rand_coord(sel);
		pin.prev_z = (sel == 1) ? pin.pos_z + 32'(int'($urandom_range(0, 8192)) - 4096)
			: rand_coord(sel);
		pin.collided_before = 1'($urandom_range(0, 1));
		pin.frame_now       = $urandom();
		pin.frame_base_in   = $urandom();
		pin.pass_start      = ($urandom_range(0, 3) == 0);
		return pin;
	endfunction

	function automatic logic [31:0] rand_normal_comp();
		case ($urandom_range(0, 5))
			0: return 32'(-65536);
			1: return 32'd65536;
			2: return 32'd0;
			3: return $urandom();
			default: return 32'(int'($urandom_range(0, 131072)) - 65536);
		endcase
	endfunction

	task automatic random_config();
		write_reg(CFG_NORMAL_X, rand_normal_comp());
		write_reg(CFG_NORMAL_Y, rand_normal_comp());
		write_reg(CFG_NORMAL_Z, rand_normal_comp());
		write_reg(CFG_PLANE_OFFSET, $urandom_range(0, 3) == 0 ? $urandom()
			: 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20)));
		write_reg(CFG_SMOOTHNESS, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 131072));
		write_reg(CFG_BOUNCE, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 131072));
		write_reg(CFG_MODE_BITS, $urandom_range(0, 15));
		write_reg(CFG_PAINT_COLOR, $urandom());
		// An index past the register list must be ignored.
		write_reg(4'd8 + 4'($urandom_range(0, 7)), $urandom());
	endtask

	// Directed stimulus: particle, whether the result is typed in, and that result.
	typedef struct {
		in_t  pin;
		bit   typed;
		out_t res;
	} directed_row_t;

	directed_row_t directed_rows[$];

	task automatic add_row(input logic [31:0] px, py, pz, qx, qy, qz,
		input bit cb, input logic [31:0] fnow, fbase, input bit ps);
		directed_row_t row;
		row.pin = {px, py, pz, qx, qy, qz, cb, fnow, fbase, ps};
		row.typed = 1'b0;
		row.res = '0;
		directed_rows.push_back(row);
	endtask

	// Receiver: random stalls, plus one long hold when asked.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_receiver) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_receiver = 1'b0;
			end
			if ($urandom_range(0, 29) == 0) out_ready <= 1'b0;
			else if ($urandom_range(0, 3) == 0) out_ready <= ~out_ready;
			else out_ready <= 1'b1;
		end
	end

	// Result check against the oldest expectation.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.new_pos_x !== want.new_pos_x) begin
					$error("new_pos_x exp %h got %h", want.new_pos_x, out_data.new_pos_x);
					error_count++;
				end
				if (out_data.new_pos_y !== want.new_pos_y) begin
					$error("new_pos_y exp %h got %h", want.new_pos_y, out_data.new_pos_y);
					error_count++;
				end
				if (out_data.new_pos_z !== want.new_pos_z) begin
					$error("new_pos_z exp %h got %h", want.new_pos_z, out_data.new_pos_z);
					error_count++;
				end
				if (out_data.new_prev_x !== want.new_prev_x) begin
					$error("new_prev_x exp %h got %h", want.new_prev_x, out_data.new_prev_x);
					error_count++;
				end
				if (out_data.new_prev_y !== want.new_prev_y) begin
					$error("new_prev_y exp %h got %h", want.new_prev_y, out_data.new_prev_y);
					error_count++;
				end
				if (out_data.new_prev_z !== want.new_prev_z) begin
					$error("new_prev_z exp %h got %h", want.new_prev_z, out_data.new_prev_z);
					error_count++;
				end
				if (out_data.hit !== want.hit) begin
					$error("hit exp %b got %b", want.hit, out_data.hit);
					error_count++;
				end
				if (out_data.killed !== want.killed) begin
					$error("killed exp %b got %b", want.killed, out_data.killed);
					error_count++;
				end
				if (out_data.recolor !== want.recolor) begin
					$error("recolor exp %b got %b", want.recolor, out_data.recolor);
					error_count++;
				end
				if (out_data.frame_base_out !== want.frame_base_out) begin
					$error("frame_base_out exp %h got %h", want.frame_base_out,
						out_data.frame_base_out);
					error_count++;
				end
				if (out_data.hit_total !== want.hit_total) begin
					$error("hit_total exp %h got %h", want.hit_total, out_data.hit_total);
					error_count++;
				end
				if (out_data.ticks_since_hit !== want.ticks_since_hit) begin
					$error("ticks_since_hit exp %h got %h", want.ticks_since_hit,
						out_data.ticks_since_hit);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || stim_done && pending_results.size() == 0)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL plane_particle_collision");
			$finish;
		end
	end

	initial begin
		directed_row_t row;
		error_count   = 0;
		idle_cycles   = 0;
		hold_receiver = 1'b0;
		stim_done     = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_idx   = '0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		pred_cfg  = '0;
		pred_cfg.normal_z   = 18'sd65536;
		pred_cfg.smoothness = 18'd65536;
		pred_hits  = '0;
		pred_ticks = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows under the reset plane z = 0, normal up.
		// A particle above the plane after reset passes untouched.
		add_row(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0, 32'h0, 32'h0,
			1'b0, 32'd5, 32'd9, 1'b1);
		directed_rows[0].typed = 1'b1;
		directed_rows[0].res = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
			32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0, 32'd9, 32'd0, 32'd1};
		// Below the plane: pushed to z = 0, first hit takes frame_now.
		add_row(32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0,
			1'b0, 32'd7, 32'd3, 1'b1);
		add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 1'b0, 32'h0, 32'h0, 1'b1);
		add_row(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8765_4321,
			1'b1, 32'hAAAA_5555, 32'h5555_AAAA, 1'b1);
		add_row(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0010_0000,
			1'b0, 32'h5555_AAAA, 32'hAAAA_5555, 1'b0);
		foreach (directed_rows[k]) begin
			row = directed_rows[k];
			if (row.typed) begin
				void'(collide_particle(row.pin));
				in_valid <= 1'b1;
				in_data  <= row.pin;
				do @(posedge clk); while (!in_ready);
				pending_results.push_back(row.res);
			end else begin
				send_particle(row.pin, 1'b0);
			end
		end
		wait_drained();

		// Mode sweep with extreme plane settings: every mode bit combination.
		for (int m = 0; m < 16; m++) begin
			write_reg(CFG_NORMAL_X, m[0] ? 32'(-65536) : 32'd65536);
			write_reg(CFG_NORMAL_Y, m[1] ? 32'h0001_FFFF : 32'h0002_0000);
			write_reg(CFG_NORMAL_Z, m[2] ? 32'd0 : 32'd65536);
			write_reg(CFG_PLANE_OFFSET, m[3] ? 32'h8000_0000 : 32'h7FFF_FFFF);
			write_reg(CFG_SMOOTHNESS, m[0] ? 32'd131072 : 32'd0);
			write_reg(CFG_BOUNCE, m[1] ? 32'h3FFFF : 32'd0);
			write_reg(CFG_MODE_BITS, m);
			write_reg(CFG_PAINT_COLOR, $urandom());
			repeat (3) send_particle(rand_particle(), 1'b1);
			wait_drained();
		end

		// Random phases with fresh settings; long receiver hold in one phase.
		for (int ph = 0; ph < 15; ph++) begin
			random_config();
			if (ph == 3) hold_receiver = 1'b1;
			if (ph == 5) begin
				// Zero plane offset so hits and misses both occur; the normal stays random.
				write_reg(CFG_PLANE_OFFSET, 32'd0);
				write_reg(CFG_MODE_BITS, 32'($urandom_range(0, 1)) | 32'h8);
			end
			repeat (RANDOM_ITEMS / 15) send_particle(rand_particle(), 1'b1);
			// Sender pause until the block has fully drained.
			wait_drained();
		end

		stim_done = 1'b1;
		wait_drained();
		if (error_count == 0) begin
			$display("PASS plane_particle_collision");
		end else begin
			$display("FAIL plane_particle_collision");
		end
		$finish;
	end

endmodule

// ===== plane_particle_collision.f =====
rtl/ppc_pkg.sv
rtl/ppc_front.sv
rtl/ppc_queue.sv
rtl/ppc_back.sv
rtl/plane_particle_collision.sv
tb/plane_particle_collision_tb.sv
